### design/ppq_pkg.sv
// Shared types, codes and widths for the positional process queue.
package ppq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 5;
    localparam int ID_W    = 16;
    localparam int DATA_W  = 32;
    localparam int FOUND_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADIDX   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [FOUND_W-1:0]   found_index;
        logic [COUNT_W-1:0]   count;
    } result_t;

endpackage

### design/positional_process_queue.sv
// Top level of the positional process queue: sequencer, slot RAM and result register.
// One request is taken at a time and the block stalls its input until the request is done.
// All slot traffic goes through a single RAM with one write and one registered read port,
// so every entry moved or examined takes a read state followed by a write or compare state.
// Clear and a rejected request go straight to the done state, from which the result is
// handed over. The result sits in an output register, so a new request is accepted while
// the previous result still waits to be taken.
module positional_process_queue #(
    parameter int DEPTH        = ppq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = ppq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ppq_pkg::REQ_W-1:0]     req_type,
    input  logic                          at_end,
    input  logic [ppq_pkg::IDX_W-1:0]     index,
    input  logic [ppq_pkg::ID_W-1:0]      proc_id,
    input  logic [ppq_pkg::DATA_W-1:0]    entry_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [ppq_pkg::FOUND_W-1:0]   found_index,
    output logic [ppq_pkg::COUNT_W-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = ppq_pkg::ID_W + PAYLOAD_BITS;

    logic              res_valid;
    logic              res_take;
    ppq_pkg::result_t  res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;

    logic              out_valid_reg;
    ppq_pkg::result_t  out_res_reg;

    ppq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .RW           (RW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .at_end     (at_end),
        .index      (index),
        .proc_id    (proc_id),
        .entry_data (entry_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    ppq_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register is free when empty or when its transaction completes this cycle.
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign found_index = out_res_reg.found_index;
    assign count       = out_res_reg.count;

endmodule

### design/ppq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/ppq_ctrl.sv
// Request sequencer: shifts, searches and counts through the shared slot RAM.
module ppq_ctrl #(
    parameter int DEPTH        = ppq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = ppq_pkg::PAYLOAD_BITS_DEF,
    parameter int AW           = $clog2(DEPTH),
    parameter int RW           = ppq_pkg::ID_W + PAYLOAD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ppq_pkg::REQ_W-1:0]   req_type,
    input  logic                        at_end,
    input  logic [ppq_pkg::IDX_W-1:0]   index,
    input  logic [ppq_pkg::ID_W-1:0]    proc_id,
    input  logic [ppq_pkg::DATA_W-1:0]  entry_data,
    output logic                        res_valid,
    output ppq_pkg::result_t            res,
    input  logic                        res_take,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [RW-1:0]               ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  logic [RW-1:0]               ram_rdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > ppq_pkg::IDX_W) ? CW : ppq_pkg::IDX_W;

    ppq_pkg::state_t    state_reg, state_next;
    ppq_pkg::status_t   status_reg, status_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      found_reg, found_next;
    logic [ppq_pkg::ID_W-1:0]  pid_reg, pid_next;
    logic [PAYLOAD_BITS-1:0]   data_reg, data_next;

    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   ins_pos;
    logic [CMP_W-1:0]   rem_pos;
    logic [ppq_pkg::ID_W-1:0]  slot_id;

    assign fill_ext = CMP_W'(fill_reg);
    assign ins_pos  = at_end ? fill_ext : CMP_W'(index);
    assign rem_pos  = at_end ? '0 : CMP_W'(index);
    assign slot_id  = ram_rdata[RW-1 -: ppq_pkg::ID_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppq_pkg::S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        pid_reg    <= pid_next;
        data_reg   <= data_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        fill_next   = fill_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        pid_next    = pid_reg;
        data_next   = data_reg;
        ram_we      = 1'b0;
        ram_waddr   = k_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = k_reg;
        in_stall    = (state_reg != ppq_pkg::S_IDLE);
        res_valid   = (state_reg == ppq_pkg::S_DONE);

        case (state_reg)
            ppq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pid_next    = proc_id;
                    data_next   = PAYLOAD_BITS'(entry_data);
                    status_next = ppq_pkg::ST_OK;
                    found_next  = '0;
                    state_next  = ppq_pkg::S_DONE;
                    case (ppq_pkg::req_t'(req_type))
                        ppq_pkg::REQ_INSERT:
                        begin
                            // The full check takes precedence over the position check.
                            if (fill_reg == CW'(DEPTH))
                            begin
                                status_next = ppq_pkg::ST_FULL;
                            end
                            else if (ins_pos > fill_ext)
                            begin
                                status_next = ppq_pkg::ST_BADIDX;
                            end
                            else
                            begin
                                pos_next = AW'(ins_pos);
                                k_next   = AW'(fill_reg);
                                if (ins_pos == fill_ext)
                                begin
                                    state_next = ppq_pkg::S_INS_PUT;
                                end
                                else
                                begin
                                    state_next = ppq_pkg::S_INS_RD;
                                end
                            end
                        end
                        ppq_pkg::REQ_REMOVE:
                        begin
                            if (rem_pos >= fill_ext)
                            begin
                                status_next = ppq_pkg::ST_BADIDX;
                            end
                            else
                            begin
                                k_next = AW'(rem_pos);
                                if (rem_pos + CMP_W'(1) < fill_ext)
                                begin
                                    state_next = ppq_pkg::S_REM_RD;
                                end
                                else
                                begin
                                    fill_next = fill_reg - CW'(1);
                                end
                            end
                        end
                        ppq_pkg::REQ_FIND:
                        begin
                            k_next = '0;
                            if (fill_reg == '0)
                            begin
                                status_next = ppq_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = ppq_pkg::S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            fill_next = '0;
                        end
                    endcase
                end
            end

            // Opening a gap: each entry from the tail down to the position moves up one slot.
            ppq_pkg::S_INS_RD:
            begin
                ram_raddr  = k_reg - AW'(1);
                state_next = ppq_pkg::S_INS_WR;
            end
            ppq_pkg::S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = ram_rdata;
                k_next    = k_reg - AW'(1);
                if (k_reg - AW'(1) == pos_reg)
                begin
                    state_next = ppq_pkg::S_INS_PUT;
                end
                else
                begin
                    state_next = ppq_pkg::S_INS_RD;
                end
            end
            ppq_pkg::S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = {pid_reg, data_reg};
                fill_next  = fill_reg + CW'(1);
                state_next = ppq_pkg::S_DONE;
            end

            // Closing the gap: each entry above the position moves down one slot.
            ppq_pkg::S_REM_RD:
            begin
                ram_raddr  = k_reg + AW'(1);
                state_next = ppq_pkg::S_REM_WR;
            end
            ppq_pkg::S_REM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = ram_rdata;
                k_next    = k_reg + AW'(1);
                if (CW'(k_reg) + CW'(2) < fill_reg)
                begin
                    state_next = ppq_pkg::S_REM_RD;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = ppq_pkg::S_DONE;
                end
            end

            ppq_pkg::S_FIND_RD:
            begin
                ram_raddr  = k_reg;
                state_next = ppq_pkg::S_FIND_CMP;
            end
            ppq_pkg::S_FIND_CMP:
            begin
                if (slot_id == pid_reg)
                begin
                    found_next = k_reg;
                    state_next = ppq_pkg::S_DONE;
                end
                else if (CW'(k_reg) + CW'(1) < fill_reg)
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = ppq_pkg::S_FIND_RD;
                end
                else
                begin
                    status_next = ppq_pkg::ST_NOTFOUND;
                    state_next  = ppq_pkg::S_DONE;
                end
            end

            ppq_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = ppq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ppq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.found_index = ppq_pkg::FOUND_W'(found_reg);
    assign res.count       = ppq_pkg::COUNT_W'(fill_reg);

endmodule

### design/ppq_checker.sv
// Port-level checks for the positional process queue, bound to the top level.
module ppq_checker #(
    parameter int DEPTH = ppq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    status,
    input  logic [ppq_pkg::FOUND_W-1:0]   found_index,
    input  logic [ppq_pkg::COUNT_W-1:0]   count
);

    // Every request keeps the block busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

    // Only a successful find can report a non-zero position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (found_index != '0) |-> status == ppq_pkg::ST_OK)
    else $error("found_index set on a failed request");

    // A full queue refusal reports the queue at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ppq_pkg::ST_FULL) |-> count == ppq_pkg::COUNT_W'(DEPTH))
    else $error("full status with queue below capacity");

    // A stalled result transaction holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
            && $stable(found_index))
    else $error("stalled result changed");

endmodule

bind positional_process_queue ppq_checker #(.DEPTH(DEPTH)) u_ppq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .count       (count)
);

### sim/positional_process_queue_tb.sv
// Self-checking testbench for the positional process queue: directed table, then random traffic.
module positional_process_queue_tb;

    localparam int QDEPTH      = ppq_pkg::DEPTH_DEF;
    localparam int RANDOM_REQS = 1420;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 80;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_RESULTS = 2048;

    typedef struct {
        ppq_pkg::req_t                  rq;
        logic                           tail;
        logic [ppq_pkg::IDX_W-1:0]      pos;
        logic [ppq_pkg::ID_W-1:0]       pid;
        logic [ppq_pkg::DATA_W-1:0]     data;
        bit                             typed;
        ppq_pkg::result_t               want;
    } request_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [ppq_pkg::REQ_W-1:0]      req_type;
    logic                           at_end;
    logic [ppq_pkg::IDX_W-1:0]      index;
    logic [ppq_pkg::ID_W-1:0]       proc_id;
    logic [ppq_pkg::DATA_W-1:0]     entry_data;
    logic                           out_valid;
    logic                           out_stall;
    logic [1:0]                     status;
    logic [ppq_pkg::FOUND_W-1:0]    found_index;
    logic [ppq_pkg::COUNT_W-1:0]    count;

    // Our own image of the queue contents.
    logic [ppq_pkg::ID_W-1:0]       held_id   [QDEPTH];
    logic [ppq_pkg::DATA_W-1:0]     held_data [QDEPTH];
    int                             held_n = 0;

    // Directed table and the results still owed by the block, in order.
    request_row_t                   directed_rows [MAX_ROWS];
    int                             directed_n = 0;
    ppq_pkg::result_t               predicted_results [MAX_RESULTS];
    int                             results_queued  = 0;
    int                             results_checked = 0;
    int                             mismatches = 0;
    bit                             send_burst = 0;

    positional_process_queue uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .at_end      (at_end),
        .index       (index),
        .proc_id     (proc_id),
        .entry_data  (entry_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .count       (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Applies one request to the queue image and returns the result it must produce.
    function automatic ppq_pkg::result_t apply_request(request_row_t r);
        ppq_pkg::result_t res;
        int               pos;
        int               k;
        res.status      = ppq_pkg::ST_OK;
        res.found_index = '0;
        pos             = r.pos;
        case (r.rq)
            ppq_pkg::REQ_INSERT:
            begin
                if (r.tail)
                    pos = held_n;
                if (held_n >= QDEPTH)
                    res.status = ppq_pkg::ST_FULL;
                else if (pos > held_n)
                    res.status = ppq_pkg::ST_BADIDX;
                else
                begin
                    for (k = held_n; k > pos; k--)
                    begin
                        held_id[k]   = held_id[k-1];
                        held_data[k] = held_data[k-1];
                    end
                    held_id[pos]   = r.pid;
                    held_data[pos] = r.data;
                    held_n++;
                end
            end
            ppq_pkg::REQ_REMOVE:
            begin
                if (r.tail)
                    pos = 0;
                if (pos >= held_n)
                    res.status = ppq_pkg::ST_BADIDX;
                else
                begin
                    for (k = pos; k + 1 < held_n; k++)
                    begin
                        held_id[k]   = held_id[k+1];
                        held_data[k] = held_data[k+1];
                    end
                    held_n--;
                end
            end
            ppq_pkg::REQ_FIND:
            begin
                res.status = ppq_pkg::ST_NOTFOUND;
                for (k = 0; k < held_n; k++)
                begin
                    if (held_id[k] == r.pid)
                    begin
                        res.status      = ppq_pkg::ST_OK;
                        res.found_index = ppq_pkg::FOUND_W'(k);
                        break;
                    end
                end
            end
            default:
                held_n = 0;
        endcase
        res.count = ppq_pkg::COUNT_W'(held_n);
        return res;
    endfunction

    function automatic void add_row(ppq_pkg::req_t rq, logic tail, int pos, int pid,
                                    logic [ppq_pkg::DATA_W-1:0] data, bit typed,
                                    ppq_pkg::status_t st, int fi, int cnt);
        request_row_t r;
        r.rq               = rq;
        r.tail             = tail;
        r.pos              = ppq_pkg::IDX_W'(pos);
        r.pid              = ppq_pkg::ID_W'(pid);
        r.data             = data;
        r.typed            = typed;
        r.want.status      = st;
        r.want.found_index = ppq_pkg::FOUND_W'(fi);
        r.want.count       = ppq_pkg::COUNT_W'(cnt);
        directed_rows[directed_n] = r;
        directed_n++;
    endfunction

    function automatic void load_directed();
        int j;
        add_row(ppq_pkg::REQ_FIND,   1'b0,  0, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_NOTFOUND, 0, 0);
        add_row(ppq_pkg::REQ_REMOVE, 1'b1,  0, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_BADIDX,   0, 0);
        add_row(ppq_pkg::REQ_INSERT, 1'b0,  1, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_BADIDX,   0, 0);
        add_row(ppq_pkg::REQ_INSERT, 1'b0,  0, 16'hFFFF, 32'hFFFFFFFF, 1,
                ppq_pkg::ST_OK,       0, 1);
        add_row(ppq_pkg::REQ_INSERT, 1'b1, 31, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_OK,       0, 2);
        add_row(ppq_pkg::REQ_REMOVE, 1'b0,  2, 16'hFFFF, 32'hFFFFFFFF, 1,
                ppq_pkg::ST_BADIDX,   0, 2);
        add_row(ppq_pkg::REQ_REMOVE, 1'b1, 31, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_OK,       0, 1);
        // Fill to the brim, with a repeated id so that find must report the first copy.
        for (j = 0; j < QDEPTH - 1; j++)
            add_row(ppq_pkg::REQ_INSERT, j % 5 == 0, (j * 3) % (j + 2),
                    (j % 4 == 0) ? 16'h00AA : 16'h0100 + j, $urandom, 0,
                    ppq_pkg::ST_OK, 0, 0);
        add_row(ppq_pkg::REQ_FIND,   1'b0,  0, 16'h00AA, 32'h0,        0,
                ppq_pkg::ST_OK,       0, 0);
        add_row(ppq_pkg::REQ_INSERT, 1'b0, 31, 16'h5555, 32'h5555AAAA, 1,
                ppq_pkg::ST_FULL,     0, 16);
        add_row(ppq_pkg::REQ_REMOVE, 1'b0, 15, 16'h0000, 32'h0,        1,
                ppq_pkg::ST_OK,       0, 15);
        add_row(ppq_pkg::REQ_FIND,   1'b0,  0, 16'h7777, 32'h0,        1,
                ppq_pkg::ST_NOTFOUND, 0, 15);
        add_row(ppq_pkg::REQ_CLEAR,  1'b1, 31, 16'hFFFF, 32'hFFFFFFFF, 1,
                ppq_pkg::ST_OK,       0, 0);
    endfunction

    // Mostly well-formed requests, leaning towards filling or draining the queue by phase.
    function automatic request_row_t random_request(bit fill_phase);
        request_row_t r;
        int           pick;
        pick    = $urandom_range(0, 99);
        r.typed = 0;
        r.want  = '{ppq_pkg::ST_OK, '0, '0};
        if (pick < (fill_phase ? 55 : 25))
            r.rq = ppq_pkg::REQ_INSERT;
        else if (pick < (fill_phase ? 75 : 70))
            r.rq = ppq_pkg::REQ_REMOVE;
        else if (pick < 99)
            r.rq = ppq_pkg::REQ_FIND;
        else
            r.rq = ppq_pkg::REQ_CLEAR;
        r.tail = ($urandom_range(0, 3) == 0);
        r.data = $urandom;
        r.pid  = ($urandom_range(0, 1) == 0) ? ppq_pkg::ID_W'($urandom_range(0, 15))
                                             : ppq_pkg::ID_W'($urandom);
        if ($urandom_range(0, 99) < 85)
        begin
            if (r.rq == ppq_pkg::REQ_INSERT)
                r.pos = ppq_pkg::IDX_W'($urandom_range(0, held_n));
            else
                r.pos = (held_n > 0) ? ppq_pkg::IDX_W'($urandom_range(0, held_n - 1)) : '0;
        end
        else
            r.pos = ppq_pkg::IDX_W'($urandom_range(0, 31));
        if (r.rq == ppq_pkg::REQ_FIND && held_n > 0 && $urandom_range(0, 99) < 60)
            r.pid = held_id[$urandom_range(0, held_n - 1)];
        return r;
    endfunction

    // Presents one request and returns at the falling edge after its transaction.
    task automatic send_request(request_row_t r);
        int               gap;
        ppq_pkg::result_t predicted;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= r.rq;
        at_end     <= r.tail;
        index      <= r.pos;
        proc_id    <= r.pid;
        entry_data <= r.data;
        predicted = apply_request(r);
        predicted_results[results_queued] = r.typed ? r.want : predicted;
        results_queued++;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        int i;
        bit fill_phase;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = ppq_pkg::REQ_INSERT;
        at_end     = 1'b0;
        index      = '0;
        proc_id    = '0;
        entry_data = '0;
        fill_phase = 1;
        load_directed();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (i = 0; i < directed_n; i++)
            send_request(directed_rows[i]);
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 64 == 0)
                fill_phase = ($urandom_range(0, 2) != 0);
            if (n % 40 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            send_request(random_request(fill_phase));
        end
        in_valid <= 1'b0;
        while (results_checked != results_queued)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off so that the queue backs up.
    initial
    begin
        int               wait_n;
        int               taken;
        bit               recv_burst;
        ppq_pkg::result_t want;
        out_stall  = 1'b0;
        taken      = 0;
        recv_burst = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 40 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            wait_n = recv_burst ? 0 : $urandom_range(0, 15);
            if (taken == HOLD_AFTER)
                wait_n = HOLD_CYCLES;
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            taken++;
            if (results_checked == results_queued)
            begin
                $error("result transaction with no request outstanding: status %0d count %0d",
                       status, count);
                mismatches++;
            end
            else
            begin
                want = predicted_results[results_checked];
                results_checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d", want.found_index, found_index);
                    mismatches++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

endmodule
